@@ rtl/ccs_pkg.sv @@
`default_nettype none

package ccs_pkg;

   // Item function codes
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

   // Result queue: room for the two pixels an ending step can give, plus slack
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = QPTR_BITS + 1;

   typedef logic [2:0] octant_type;

   // Per-octant moves: square move (dx1,dy1) and diagonal move (dx2,dy2)
   typedef struct packed {
      logic signed [1:0] dx1;
      logic signed [1:0] dy1;
      logic signed [1:0] dx2;
      logic signed [1:0] dy2;
   } move_type;

   localparam move_type MOVE_TAB [8] = '{
      '{2'b01, 2'b00, 2'b01, 2'b01},
      '{2'b00, 2'b01, 2'b01, 2'b01},
      '{2'b00, 2'b01, 2'b11, 2'b01},
      '{2'b11, 2'b00, 2'b11, 2'b01},
      '{2'b11, 2'b00, 2'b11, 2'b11},
      '{2'b00, 2'b11, 2'b11, 2'b11},
      '{2'b00, 2'b11, 2'b01, 2'b11},
      '{2'b01, 2'b00, 2'b01, 2'b11}
   };

   localparam octant_type AFTER_DIAG [8] = '{
      3'd1, 3'd0, 3'd3, 3'd2, 3'd5, 3'd4, 3'd7, 3'd6
   };

   localparam octant_type AFTER_SQUARE [8] = '{
      3'd7, 3'd2, 3'd1, 3'd4, 3'd3, 3'd6, 3'd5, 3'd0
   };

   // Index is {v negative, u negative, |v| > |u|}
   localparam octant_type OCT_MAP [8] = '{
      3'd0, 3'd1, 3'd3, 3'd2, 3'd7, 3'd6, 3'd4, 3'd5
   };

   // Pixels a transaction pushes into the result queue
   typedef struct packed {
      logic first;
      logic second;
   } ccs_push_type;

   // Outcome of one step
   typedef struct packed {
      logic done;
      logic extra;
   } ccs_step_flags_type;

endpackage

`default_nettype wire

@@ rtl/ccs_setup.sv @@
`default_nettype none

module ccs_setup #(
   parameter int COEF_BITS = 32
) (
   input  logic signed [COEF_BITS-1:0] alpha,
   input  logic signed [COEF_BITS-1:0] beta,
   input  logic signed [COEF_BITS-1:0] gamma,
   input  logic signed [COEF_BITS-1:0] coef_u,
   input  logic signed [COEF_BITS-1:0] coef_v,
   output logic signed [COEF_BITS-1:0] k1,
   output logic signed [COEF_BITS-1:0] k2,
   output logic signed [COEF_BITS-1:0] k3,
   output logic signed [COEF_BITS-1:0] var_a,
   output logic signed [COEF_BITS-1:0] var_b,
   output logic signed [COEF_BITS-1:0] var_d,
   output ccs_pkg::octant_type         octant
);
   import ccs_pkg::*;

   logic                        neg_u;
   logic                        neg_v;
   logic [COEF_BITS-1:0]        mag_u;
   logic [COEF_BITS-1:0]        mag_v;
   logic                        swap;
   logic signed [COEF_BITS-1:0] al_s, be_s, ga_s, u_s, v_s;
   logic signed [COEF_BITS-1:0] al_f, be_f, u_f, v_f;
   logic                        flip_v;

   assign neg_u = coef_u[COEF_BITS-1];
   assign neg_v = coef_v[COEF_BITS-1];
   // most negative value reads as the largest magnitude
   assign mag_u = neg_u ? -coef_u : coef_u;
   assign mag_v = neg_v ? -coef_v : coef_v;
   assign swap  = mag_v > mag_u;

   assign octant = OCT_MAP[{neg_v, neg_u, swap}];

   assign al_s = swap ? beta   : alpha;
   assign be_s = swap ? alpha  : beta;
   assign u_s  = swap ? coef_v : coef_u;
   assign v_s  = swap ? coef_u : coef_v;
   assign ga_s = swap ? -gamma : gamma;

   assign al_f   = octant[0] ? -al_s : al_s;
   assign be_f   = octant[0] ? -be_s : be_s;
   assign u_f    = (octant > 3'd2 && octant < 3'd7) ? -u_s : u_s;
   assign flip_v = (octant > 3'd3) ^ (octant[1:0] == 2'd2);
   assign v_f    = flip_v ? -v_s : v_s;

   assign k1    = be_f <<< 1;
   assign k2    = k1 + (ga_s <<< 1);
   assign k3    = (al_f <<< 1) + (ga_s <<< 1) + k2;
   assign var_b = (v_f <<< 1) - be_f - ga_s;
   assign var_a = (u_f <<< 1) - var_b;
   assign var_d = var_b - u_f - (al_f >>> 2);

endmodule

`default_nettype wire

@@ rtl/ccs_advance.sv @@
`default_nettype none

module ccs_advance #(
   parameter int COORD_BITS = 16,
   parameter int COEF_BITS  = 32
) (
   input  ccs_pkg::octant_type          octant,
   input  logic signed [COEF_BITS-1:0]  k1,
   input  logic signed [COEF_BITS-1:0]  k2,
   input  logic signed [COEF_BITS-1:0]  k3,
   input  logic signed [COEF_BITS-1:0]  var_a,
   input  logic signed [COEF_BITS-1:0]  var_b,
   input  logic signed [COEF_BITS-1:0]  var_d,
   input  logic signed [COORD_BITS-1:0] cur_x,
   input  logic signed [COORD_BITS-1:0] cur_y,
   input  logic signed [COORD_BITS-1:0] stop_x,
   input  logic signed [COORD_BITS-1:0] stop_y,
   input  logic [4:0]                   oct_changes,
   input  logic [3:0]                   limit_oct,
   input  logic [7:0]                   tol,
   output ccs_pkg::octant_type          next_octant,
   output logic signed [COEF_BITS-1:0]  next_k1,
   output logic signed [COEF_BITS-1:0]  next_k2,
   output logic signed [COEF_BITS-1:0]  next_k3,
   output logic signed [COEF_BITS-1:0]  next_a,
   output logic signed [COEF_BITS-1:0]  next_b,
   output logic signed [COEF_BITS-1:0]  next_d,
   output logic signed [COORD_BITS-1:0] next_x,
   output logic signed [COORD_BITS-1:0] next_y,
   output logic [4:0]                   next_changes,
   output ccs_pkg::ccs_step_flags_type  flags
);
   import ccs_pkg::*;

   move_type                     mv;
   logic                         square_mv;
   logic signed [1:0]            dx;
   logic signed [1:0]            dy;
   logic signed [COEF_BITS-1:0]  a1, b1, d1;
   logic signed [COORD_BITS-1:0] diff_x, diff_y;
   logic [COORD_BITS-1:0]        mag_x, mag_y;
   logic                         near;
   logic [4:0]                   cnt_inc;
   logic                         over;
   // square octant change
   logic signed [COEF_BITS-1:0]  ws, k1s, k2s, k3s, as_, bs, ds;
   // diagonal octant change
   logic signed [COEF_BITS-1:0]  wg, k1g, k2g, k3g, ag, bg, dg;

   assign mv        = MOVE_TAB[octant];
   assign square_mv = var_d[COEF_BITS-1];
   assign dx        = square_mv ? mv.dx1 : mv.dx2;
   assign dy        = square_mv ? mv.dy1 : mv.dy2;

   assign next_x = cur_x + COORD_BITS'(dx);
   assign next_y = cur_y + COORD_BITS'(dy);

   assign b1 = square_mv ? var_b - k1 : var_b - k2;
   assign a1 = square_mv ? var_a + k2 : var_a + k3;
   assign d1 = square_mv ? var_d + b1 : var_d - a1;

   assign diff_x = next_x - stop_x;
   assign diff_y = next_y - stop_y;
   assign mag_x  = diff_x[COORD_BITS-1] ? -diff_x : diff_x;
   assign mag_y  = diff_y[COORD_BITS-1] ? -diff_y : diff_y;
   assign near   = (mag_x < COORD_BITS'(tol)) && (mag_y < COORD_BITS'(tol));

   assign cnt_inc = oct_changes + 5'd1;
   assign over    = cnt_inc > {1'b0, limit_oct};

   assign ws  = k2 - k1;
   assign k1s = -k1;
   assign k2s = k1s + ws;
   assign k3s = (ws <<< 2) - k3;
   assign bs  = -ws - b1;
   assign ds  = bs - a1 - d1;
   assign as_ = a1 - (bs <<< 1) - ws;

   assign wg  = (k2 <<< 1) - k3;
   assign k1g = wg - k1;
   assign k2g = k2 - k3;
   assign k3g = -k3;
   assign bg  = b1 + a1 - (k2g >>> 1);
   assign dg  = bg - (a1 >>> 1) - d1 + (k3g >>> 3);
   assign ag  = (wg >>> 1) - a1;

   always_comb begin
      next_octant  = octant;
      next_k1      = k1;
      next_k2      = k2;
      next_k3      = k3;
      next_a       = a1;
      next_b       = b1;
      next_d       = d1;
      next_changes = oct_changes;
      flags.done   = 1'b0;
      priority if (near) begin
         flags.done = 1'b1;
      end else if (b1[COEF_BITS-1]) begin
         next_octant  = AFTER_SQUARE[octant];
         next_k1      = k1s;
         next_k2      = k2s;
         next_k3      = k3s;
         next_a       = as_;
         next_b       = bs;
         next_d       = ds;
         next_changes = cnt_inc;
         flags.done   = over;
      end else if (a1[COEF_BITS-1]) begin
         next_octant  = AFTER_DIAG[octant];
         next_k1      = k1g;
         next_k2      = k2g;
         next_k3      = k3g;
         next_a       = ag;
         next_b       = bg;
         next_d       = dg;
         next_changes = cnt_inc;
         flags.done   = over;
      end else begin
         flags.done = 1'b0;
      end
      // add the exact end point when the curve stops short of it
      flags.extra = flags.done && ((next_x != stop_x) || (next_y != stop_y));
   end

endmodule

`default_nettype wire

@@ rtl/ccs_rsp_queue.sv @@
`default_nettype none

module ccs_rsp_queue #(
   parameter int DATA_BITS = 33
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ccs_pkg::ccs_push_type         push,
   input  logic [DATA_BITS-1:0]          first_data,
   input  logic [DATA_BITS-1:0]          second_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [DATA_BITS-1:0]          rsp_data,
   output logic [ccs_pkg::QCNT_BITS-1:0] level
);
   import ccs_pkg::*;

   logic [DATA_BITS-1:0] mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 pop;

   assign rsp_valid = count_ff != '0;
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign level     = count_ff;
   assign pop       = rsp_valid && rsp_ready;

   assign wr_ptr_in = wr_ptr_ff + QPTR_BITS'(push.first) + QPTR_BITS'(push.second);
   assign rd_ptr_in = rd_ptr_ff + QPTR_BITS'(pop);
   assign count_in  = count_ff + QCNT_BITS'(push.first) + QCNT_BITS'(push.second)
                      - QCNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         mem_ff[wr_ptr_ff] <= first_data;
      end
      if (push.second) begin
         mem_ff[wr_ptr_ff + QPTR_BITS'(1)] <= second_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/conic_curve_stepper_unit.sv @@
// Conic curve stepper: rasterises alpha*y*y + beta*x*x + 2*gamma*x*y + 2*u*y - 2*v*x = 0
// from a start pixel by midpoint decision variables. A start transaction (func 0) loads
// the curve and returns the start pixel; each step transaction (func 1) returns the next
// pixel, and the ending step also returns the exact end point when it differs, flagged
// by rsp_last. A step with no curve running returns nothing. Every transaction is
// worked in the cycle it is accepted, so one transaction per clock is taken and the first
// pixel is offered on rsp_ the following cycle. Pixels wait in a four-entry result
// queue; req_ready drops while fewer than two entries are free, so input stalls when
// the result side holds back, and when a second two-pixel ending step
// arrives before an input gap has let the queue drain.
`default_nettype none

module conic_curve_stepper_unit #(
   parameter int COORD_BITS = 16,
   parameter int COEF_BITS  = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_func,
   input  logic signed [COEF_BITS-1:0]  req_coef_alpha,
   input  logic signed [COEF_BITS-1:0]  req_coef_beta,
   input  logic signed [COEF_BITS-1:0]  req_coef_gamma,
   input  logic signed [COEF_BITS-1:0]  req_coef_u,
   input  logic signed [COEF_BITS-1:0]  req_coef_v,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   input  logic [3:0]                   req_max_oct,
   input  logic [7:0]                   req_tolerance,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic                         rsp_last
);
   import ccs_pkg::*;

   localparam int DATA_BITS = 2 * COORD_BITS + 1;

   logic                         active_ff, active_in;
   octant_type                   octant_ff, octant_in;
   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [COORD_BITS-1:0] stop_x_ff, stop_x_in, stop_y_ff, stop_y_in;
   logic signed [COEF_BITS-1:0]  k1_ff, k1_in, k2_ff, k2_in, k3_ff, k3_in;
   logic signed [COEF_BITS-1:0]  a_ff, a_in, b_ff, b_in, d_ff, d_in;
   logic [4:0]                   changes_ff, changes_in;
   logic [3:0]                   limit_ff, limit_in;
   logic [7:0]                   tol_ff, tol_in;

   logic                         accept;
   logic                         is_start;
   logic                         is_step;

   octant_type                   su_octant;
   logic signed [COEF_BITS-1:0]  su_k1, su_k2, su_k3, su_a, su_b, su_d;

   octant_type                   st_octant;
   logic signed [COEF_BITS-1:0]  st_k1, st_k2, st_k3, st_a, st_b, st_d;
   logic signed [COORD_BITS-1:0] st_x, st_y;
   logic [4:0]                   st_changes;
   ccs_step_flags_type           st_flags;

   ccs_push_type                 push;
   logic [DATA_BITS-1:0]         first_data;
   logic [DATA_BITS-1:0]         second_data;
   logic [DATA_BITS-1:0]         rsp_data;
   logic [QCNT_BITS-1:0]         level;

   assign req_ready = level <= QCNT_BITS'(QUEUE_DEPTH - 2);
   assign accept    = req_valid && req_ready;
   assign is_start  = accept && (req_func == FUNC_START);
   assign is_step   = accept && (req_func == FUNC_STEP) && active_ff;

   ccs_setup #(
      .COEF_BITS (COEF_BITS)
   ) u_setup (
      .alpha  (req_coef_alpha),
      .beta   (req_coef_beta),
      .gamma  (req_coef_gamma),
      .coef_u (req_coef_u),
      .coef_v (req_coef_v),
      .k1     (su_k1),
      .k2     (su_k2),
      .k3     (su_k3),
      .var_a  (su_a),
      .var_b  (su_b),
      .var_d  (su_d),
      .octant (su_octant)
   );

   ccs_advance #(
      .COORD_BITS (COORD_BITS),
      .COEF_BITS  (COEF_BITS)
   ) u_advance (
      .octant       (octant_ff),
      .k1           (k1_ff),
      .k2           (k2_ff),
      .k3           (k3_ff),
      .var_a        (a_ff),
      .var_b        (b_ff),
      .var_d        (d_ff),
      .cur_x        (cur_x_ff),
      .cur_y        (cur_y_ff),
      .stop_x       (stop_x_ff),
      .stop_y       (stop_y_ff),
      .oct_changes  (changes_ff),
      .limit_oct    (limit_ff),
      .tol          (tol_ff),
      .next_octant  (st_octant),
      .next_k1      (st_k1),
      .next_k2      (st_k2),
      .next_k3      (st_k3),
      .next_a       (st_a),
      .next_b       (st_b),
      .next_d       (st_d),
      .next_x       (st_x),
      .next_y       (st_y),
      .next_changes (st_changes),
      .flags        (st_flags)
   );

   always_comb begin
      active_in  = active_ff;
      octant_in  = octant_ff;
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      stop_x_in  = stop_x_ff;
      stop_y_in  = stop_y_ff;
      k1_in      = k1_ff;
      k2_in      = k2_ff;
      k3_in      = k3_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      d_in       = d_ff;
      changes_in = changes_ff;
      limit_in   = limit_ff;
      tol_in     = tol_ff;
      priority if (is_start) begin
         // abandon any running curve
         active_in  = 1'b1;
         octant_in  = su_octant;
         cur_x_in   = req_start_x;
         cur_y_in   = req_start_y;
         stop_x_in  = req_end_x;
         stop_y_in  = req_end_y;
         k1_in      = su_k1;
         k2_in      = su_k2;
         k3_in      = su_k3;
         a_in       = su_a;
         b_in       = su_b;
         d_in       = su_d;
         changes_in = '0;
         limit_in   = req_max_oct;
         tol_in     = req_tolerance;
      end else if (is_step) begin
         active_in  = !st_flags.done;
         octant_in  = st_octant;
         cur_x_in   = st_x;
         cur_y_in   = st_y;
         k1_in      = st_k1;
         k2_in      = st_k2;
         k3_in      = st_k3;
         a_in       = st_a;
         b_in       = st_b;
         d_in       = st_d;
         changes_in = st_changes;
      end else begin
         active_in = active_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         octant_ff  <= '0;
         cur_x_ff   <= '0;
         cur_y_ff   <= '0;
         stop_x_ff  <= '0;
         stop_y_ff  <= '0;
         k1_ff      <= '0;
         k2_ff      <= '0;
         k3_ff      <= '0;
         a_ff       <= '0;
         b_ff       <= '0;
         d_ff       <= '0;
         changes_ff <= '0;
         limit_ff   <= '0;
         tol_ff     <= '0;
      end else begin
         active_ff  <= active_in;
         octant_ff  <= octant_in;
         cur_x_ff   <= cur_x_in;
         cur_y_ff   <= cur_y_in;
         stop_x_ff  <= stop_x_in;
         stop_y_ff  <= stop_y_in;
         k1_ff      <= k1_in;
         k2_ff      <= k2_in;
         k3_ff      <= k3_in;
         a_ff       <= a_in;
         b_ff       <= b_in;
         d_ff       <= d_in;
         changes_ff <= changes_in;
         limit_ff   <= limit_in;
         tol_ff     <= tol_in;
      end
   end

   assign push.first  = is_start || is_step;
   assign push.second = is_step && st_flags.extra;

   assign first_data = is_start
      ? {req_start_x, req_start_y, 1'b0}
      : {st_x, st_y, st_flags.done && !st_flags.extra};
   assign second_data = {stop_x_ff, stop_y_ff, 1'b1};

   ccs_rsp_queue #(
      .DATA_BITS (DATA_BITS)
   ) u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .first_data  (first_data),
      .second_data (second_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .level       (level)
   );

   assign rsp_pixel_x = rsp_data[DATA_BITS-1 -: COORD_BITS];
   assign rsp_pixel_y = rsp_data[COORD_BITS:1];
   assign rsp_last    = rsp_data[0];

   a_queue_room : assert property (@(posedge clock) disable iff (reset)
      accept |-> (level <= QCNT_BITS'(QUEUE_DEPTH - 2)))
      else $error("transaction accepted without room for two pixels");

   a_start_runs : assert property (@(posedge clock) disable iff (reset)
      is_start |=> active_ff)
      else $error("curve not running after start");

   a_extra_ends : assert property (@(posedge clock) disable iff (reset)
      push.second |-> (push.first && st_flags.done))
      else $error("end point pushed on a non-ending step");

   a_push_shows : assert property (@(posedge clock) disable iff (reset)
      push.first |=> rsp_valid)
      else $error("pushed pixel not offered");

   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      (is_step && st_flags.done) |=> !active_ff)
      else $error("curve still running after its last pixel");

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import ccs_pkg::*;

   localparam int COORD_W      = 16;
   localparam int COEF_W       = 32;
   localparam int ITEM_GOAL    = 1420;
   localparam int CALM_AFTER   = 1250;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 16;

   // Octant tables, three bits per entry, octant 0 in the low bits
   localparam logic [23:0] PICK_OCT       = {3'd5, 3'd4, 3'd6, 3'd7, 3'd2, 3'd3, 3'd1, 3'd0};
   localparam logic [23:0] NEXT_ON_DIAG   = {3'd6, 3'd7, 3'd4, 3'd5, 3'd2, 3'd3, 3'd0, 3'd1};
   localparam logic [23:0] NEXT_ON_SQUARE = {3'd0, 3'd5, 3'd6, 3'd3, 3'd4, 3'd1, 3'd2, 3'd7};

   // Unit moves per octant, two-bit signed, octant 0 in the low bits
   localparam logic [15:0] SQ_DX = {2'b01, 2'b00, 2'b00, 2'b11, 2'b11, 2'b00, 2'b00, 2'b01};
   localparam logic [15:0] SQ_DY = {2'b00, 2'b11, 2'b11, 2'b00, 2'b00, 2'b01, 2'b01, 2'b00};
   localparam logic [15:0] DG_DX = {2'b01, 2'b01, 2'b11, 2'b11, 2'b11, 2'b11, 2'b01, 2'b01};
   localparam logic [15:0] DG_DY = {2'b11, 2'b11, 2'b11, 2'b11, 2'b01, 2'b01, 2'b01, 2'b01};

   typedef struct packed {
      logic        func;
      logic [31:0] alpha;
      logic [31:0] beta;
      logic [31:0] gamma;
      logic [31:0] lin_u;
      logic [31:0] lin_v;
      logic [15:0] x0;
      logic [15:0] y0;
      logic [15:0] x1;
      logic [15:0] y1;
      logic [3:0]  oct_limit;
      logic [7:0]  tol;
   } curve_item_type;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic        fin;
   } pixel_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_func = FUNC_STEP;
   logic signed [31:0] req_coef_alpha = '0;
   logic signed [31:0] req_coef_beta = '0;
   logic signed [31:0] req_coef_gamma = '0;
   logic signed [31:0] req_coef_u = '0;
   logic signed [31:0] req_coef_v = '0;
   logic signed [15:0] req_start_x = '0;
   logic signed [15:0] req_start_y = '0;
   logic signed [15:0] req_end_x = '0;
   logic signed [15:0] req_end_y = '0;
   logic [3:0]         req_max_oct = '0;
   logic [7:0]         req_tolerance = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b1;
   logic signed [15:0] rsp_pixel_x;
   logic signed [15:0] rsp_pixel_y;
   logic               rsp_last;

   // Tracker state of the curve being drawn
   logic        run_on = 1'b0;
   octant_type  oct_now = '0;
   logic [15:0] pos_x = '0, pos_y = '0, goal_x = '0, goal_y = '0;
   logic [31:0] k1 = '0, k2 = '0, k3 = '0, dv_a = '0, dv_b = '0, dv_d = '0;
   logic [4:0]  turns = '0;
   logic [3:0]  turn_limit = '0;
   logic [7:0]  tol_now = '0;

   pixel_type pixels_due [$];
   int        idle_pct = 20;
   int        items_sent = 0;
   int        mismatches = 0;
   int        pixels_checked = 0;
   int        finals_seen = 0;
   int        curves_started = 0;
   int        turn_total = 0;

   conic_curve_stepper_unit #(
      .COORD_BITS(COORD_W),
      .COEF_BITS (COEF_W)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_coef_alpha(req_coef_alpha),
      .req_coef_beta (req_coef_beta),
      .req_coef_gamma(req_coef_gamma),
      .req_coef_u    (req_coef_u),
      .req_coef_v    (req_coef_v),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_end_x     (req_end_x),
      .req_end_y     (req_end_y),
      .req_max_oct   (req_max_oct),
      .req_tolerance (req_tolerance),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_x   (rsp_pixel_x),
      .rsp_pixel_y   (rsp_pixel_y),
      .rsp_last      (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] coef_mag(logic [31:0] v);
      return v[31] ? -v : v;
   endfunction

   function automatic logic [15:0] coord_mag(logic [15:0] v);
      return v[15] ? -v : v;
   endfunction

   function automatic logic [31:0] coef_sar(logic [31:0] v, int s);
      return $signed(v) >>> s;
   endfunction

   function automatic logic [15:0] nudge(logic [15:0] p, logic [15:0] tab, octant_type o);
      logic [1:0] d;
      d = tab[o*2 +: 2];
      return p + {{14{d[1]}}, d};
   endfunction

   function automatic curve_item_type make_start(logic [31:0] al, logic [31:0] be,
                                                 logic [31:0] ga, logic [31:0] lu,
                                                 logic [31:0] lv, logic [15:0] x0,
                                                 logic [15:0] y0, logic [15:0] x1,
                                                 logic [15:0] y1, logic [3:0] lim,
                                                 logic [7:0] tol);
      curve_item_type it;
      it.func = FUNC_START;
      it.alpha = al;
      it.beta = be;
      it.gamma = ga;
      it.lin_u = lu;
      it.lin_v = lv;
      it.x0 = x0;
      it.y0 = y0;
      it.x1 = x1;
      it.y1 = y1;
      it.oct_limit = lim;
      it.tol = tol;
      return it;
   endfunction

   // Step with random filler in the ignored fields
   function automatic curve_item_type step_item();
      curve_item_type it;
      it = make_start($urandom, $urandom, $urandom, $urandom, $urandom,
                      16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      4'($urandom), 8'($urandom));
      it.func = FUNC_STEP;
      return it;
   endfunction

   function automatic void expect_pixel(logic [15:0] x, logic [15:0] y, logic fin);
      pixel_type p;
      p.x = x;
      p.y = y;
      p.fin = fin;
      pixels_due.push_back(p);
   endfunction

   task automatic predict_pixels(input curve_item_type it);
      logic [31:0] al, be, ga, cu, cv, tmp, w;
      logic [2:0]  pick;
      logic        done;
      if (it.func == FUNC_START) begin
         al = it.alpha;
         be = it.beta;
         ga = it.gamma;
         cu = it.lin_u;
         cv = it.lin_v;
         pick = {cv[31], cu[31], coef_mag(cv) > coef_mag(cu)};
         if (pick[0]) begin
            tmp = al; al = be; be = tmp;
            tmp = cu; cu = cv; cv = tmp;
            ga = -ga;
         end
         oct_now = PICK_OCT[pick*3 +: 3];
         if (oct_now[0]) begin
            be = -be;
            al = -al;
         end
         if (oct_now > 3'd2 && oct_now < 3'd7) cu = -cu;
         if (oct_now > 3'd3) cv = -cv;
         if (oct_now[1:0] == 2'd2) cv = -cv;
         k1 = be << 1;
         k2 = k1 + (ga << 1);
         k3 = (al << 1) + (ga << 1) + k2;
         dv_b = (cv << 1) - be - ga;
         dv_a = (cu << 1) - dv_b;
         dv_d = dv_b - cu - coef_sar(al, 2);
         pos_x = it.x0;
         pos_y = it.y0;
         goal_x = it.x1;
         goal_y = it.y1;
         turn_limit = it.oct_limit;
         tol_now = it.tol;
         turns = '0;
         run_on = 1'b1;
         curves_started++;
         expect_pixel(pos_x, pos_y, 1'b0);
         return;
      end
      if (!run_on) return;
      if (dv_d[31]) begin
         pos_x = nudge(pos_x, SQ_DX, oct_now);
         pos_y = nudge(pos_y, SQ_DY, oct_now);
         dv_b = dv_b - k1;
         dv_a = dv_a + k2;
         dv_d = dv_d + dv_b;
      end else begin
         pos_x = nudge(pos_x, DG_DX, oct_now);
         pos_y = nudge(pos_y, DG_DY, oct_now);
         dv_b = dv_b - k2;
         dv_a = dv_a + k3;
         dv_d = dv_d - dv_a;
      end
      done = 1'b0;
      if (coord_mag(pos_x - goal_x) < {8'd0, tol_now} &&
          coord_mag(pos_y - goal_y) < {8'd0, tol_now}) begin
         done = 1'b1;
      end else if (dv_b[31]) begin
         w = k2 - k1;
         oct_now = NEXT_ON_SQUARE[oct_now*3 +: 3];
         k1 = -k1;
         k2 = k1 + w;
         k3 = (w << 2) - k3;
         dv_b = -w - dv_b;
         dv_d = dv_b - dv_a - dv_d;
         dv_a = dv_a - (dv_b << 1) - w;
         turns = turns + 1'b1;
         turn_total++;
         done = turns > {1'b0, turn_limit};
      end else if (dv_a[31]) begin
         w = (k2 << 1) - k3;
         oct_now = NEXT_ON_DIAG[oct_now*3 +: 3];
         k1 = w - k1;
         k2 = k2 - k3;
         k3 = -k3;
         dv_b = dv_b + dv_a - coef_sar(k2, 1);
         dv_d = dv_b - coef_sar(dv_a, 1) - dv_d + coef_sar(k3, 3);
         dv_a = coef_sar(w, 1) - dv_a;
         turns = turns + 1'b1;
         turn_total++;
         done = turns > {1'b0, turn_limit};
      end
      if (!done) begin
         expect_pixel(pos_x, pos_y, 1'b0);
      end else begin
         run_on = 1'b0;
         if (pos_x != goal_x || pos_y != goal_y) begin
            expect_pixel(pos_x, pos_y, 1'b0);
            expect_pixel(goal_x, goal_y, 1'b1);
         end else begin
            expect_pixel(pos_x, pos_y, 1'b1);
         end
      end
   endtask

   task automatic send_item(input curve_item_type it);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      // steps with no curve running are ignored by the block
      if (it.func == FUNC_START || run_on) items_sent++;
      req_func <= it.func;
      req_coef_alpha <= it.alpha;
      req_coef_beta <= it.beta;
      req_coef_gamma <= it.gamma;
      req_coef_u <= it.lin_u;
      req_coef_v <= it.lin_v;
      req_start_x <= it.x0;
      req_start_y <= it.y0;
      req_end_x <= it.x1;
      req_end_y <= it.y1;
      req_max_oct <= it.oct_limit;
      req_tolerance <= it.tol;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_pixels(it);
   endtask

   task automatic check_pixel();
      pixel_type want;
      if (pixels_due.size() == 0) begin
         if (mismatches < 10)
            $display("unexpected pixel (%0d,%0d) last=%0b", rsp_pixel_x, rsp_pixel_y, rsp_last);
         mismatches++;
      end else begin
         want = pixels_due.pop_front();
         pixels_checked++;
         if (rsp_last) finals_seen++;
         if (rsp_pixel_x !== want.x || rsp_pixel_y !== want.y || rsp_last !== want.fin) begin
            if (mismatches < 10)
               $display("pixel %0d: expected (%0d,%0d) last=%0b, got (%0d,%0d) last=%0b",
                        pixels_checked, $signed(want.x), $signed(want.y), want.fin,
                        rsp_pixel_x, rsp_pixel_y, rsp_last);
            mismatches++;
         end
      end
   endtask

   initial begin : pixel_sink
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) check_pixel();
         if (hold > 0) begin
            hold--;
            if (hold == 0) rsp_ready <= 1'b1;
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            hold = $urandom_range(1, 10);
            rsp_ready <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic test_idle_step();
      send_item(step_item());
   endtask

   task automatic test_field_extremes();
      // top of every range, v at the most negative value so it wins the magnitude test
      send_item(make_start(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h8000_0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                           4'd15, 8'd255));
      send_item(step_item());
      // bottom of every range but the end point; zero tolerance never ends by distance
      send_item(make_start(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                           4'd0, 8'd0));
      send_item(step_item());
   endtask

   task automatic test_octant_choice();
      int lu, lv;
      for (int c = 0; c < 8; c++) begin
         lu = c[0] ? 7 : 20;
         lv = c[0] ? 20 : 7;
         if (c[1]) lu = -lu;
         if (c[2]) lv = -lv;
         send_item(make_start(32'd4, 32'd4, 32'd0, lu, lv, 16'd0, 16'd0,
                              16'd1000, 16'd1000, 4'd15, 8'd0));
         send_item(step_item());
      end
   endtask

   task automatic test_exact_landing();
      curve_item_type it;
      logic [15:0] nx, ny;
      it = make_start(32'd4, 32'd4, 32'd0, 32'd40, 32'd12, 16'd100, -16'sd50,
                      16'd0, 16'd0, 4'd15, 8'd0);
      send_item(it);
      // aim the end at the pixel the first move will reach
      if (dv_d[31]) begin
         nx = nudge(pos_x, SQ_DX, oct_now);
         ny = nudge(pos_y, SQ_DY, oct_now);
      end else begin
         nx = nudge(pos_x, DG_DX, oct_now);
         ny = nudge(pos_y, DG_DY, oct_now);
      end
      it.x1 = nx;
      it.y1 = ny;
      it.tol = 8'd1;
      // restart abandons the running curve
      send_item(it);
      send_item(step_item());
   endtask

   task automatic test_random_curves();
      int scale, rad, shape, al, be, ga, lu, lv, steps, cap;
      logic [15:0] x0, y0, x1, y1;
      logic [7:0]  tol;
      logic [3:0]  lim;
      while (items_sent < ITEM_GOAL) begin
         idle_pct = (items_sent > CALM_AFTER) ? 0 : 15 * int'($urandom_range(0, 2));
         if ($urandom_range(0, 4) == 0) begin
            send_item(make_start($urandom, $urandom, $urandom, $urandom, $urandom,
                                 16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), 4'($urandom), 8'($urandom)));
            cap = $urandom_range(1, 40);
         end else begin
            scale = $urandom_range(1, 8);
            rad = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 45) : $urandom_range(2, 15);
            shape = $urandom_range(0, 3);
            al = scale;
            be = scale;
            ga = 0;
            if (shape == 1) begin
               // ellipse: keep gamma squared below alpha times beta
               al = scale * $urandom_range(1, 4);
               be = scale * $urandom_range(1, 4);
               ga = int'($urandom_range(0, scale)) - scale / 2;
            end else if (shape == 2) begin
               be = -scale * $urandom_range(1, 3);
               ga = int'($urandom_range(0, 2 * scale)) - scale;
            end else if (shape == 3) begin
               be = 0;
            end
            lu = int'($urandom_range(0, 2 * rad * scale)) - rad * scale;
            lv = int'($urandom_range(0, 2 * rad * scale)) - rad * scale;
            x0 = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                             : 16'(int'($urandom_range(0, 2000)) - 1000);
            y0 = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                             : 16'(int'($urandom_range(0, 2000)) - 1000);
            if ($urandom_range(0, 1) == 0) begin
               x1 = x0;
               y1 = y0;
            end else begin
               x1 = x0 + 16'(int'($urandom_range(0, 4 * rad)) - 2 * rad);
               y1 = y0 + 16'(int'($urandom_range(0, 4 * rad)) - 2 * rad);
            end
            tol = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
            lim = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(6, 15));
            send_item(make_start(al, be, ga, lu, lv, x0, y0, x1, y1, lim, tol));
            cap = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 400;
         end
         steps = 0;
         while (run_on && steps < cap) begin
            send_item(step_item());
            steps++;
         end
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 2)) send_item(step_item());
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_idle_step();
      test_field_extremes();
      test_octant_choice();
      test_exact_landing();
      test_random_curves();
      req_valid <= 1'b0;
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      mismatches += pixels_due.size();
      $display("Drew %0d curves from %0d transactions with %0d octant changes",
               curves_started, items_sent, turn_total);
      $display("Checked %0d pixels, %0d of them curve ends", pixels_checked, finals_seen);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
